@@ sv/gsg_pkg.sv @@
// ----------------------------------------------------------------------------
// gsg_pkg
// Shared types and constants for the gapped sawtooth generator.
// ----------------------------------------------------------------------------
package gsg_pkg;

  // Field widths
  localparam int SpeedW = 24;
  localparam int SawW   = 22;
  localparam int GapW   = 22;
  localparam int FullW  = 23;
  localparam int DtW    = 16;
  localparam int PosW   = 24;
  localparam int LevelW = 16;
  localparam int PhaseW = 24;
  localparam int IdxW   = 2;
  localparam int DataW  = 24;

  // Width of the partial remainder seen by the compare-subtract unit
  localparam int TrialW = FullW + 1;

  // Register indexes
  localparam logic [IdxW-1:0] RegSpeed    = 2'd0;
  localparam logic [IdxW-1:0] RegSawWidth = 2'd1;
  localparam logic [IdxW-1:0] RegGapWidth = 2'd2;

  // Reset values
  localparam logic signed [SpeedW-1:0] SpeedReset    = 24'sd4096;
  localparam logic [SawW-1:0]          SawWidthReset = 22'd4096;
  localparam logic [GapW-1:0]          GapWidthReset = 22'd0;

  // Operation codes
  localparam logic OpTick = 1'b0;
  localparam logic OpEval = 1'b1;

  // Configuration handed to the engine
  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic [SawW-1:0]          saw_width;
    logic [GapW-1:0]          gap_width;
  } gsg_cfg_t;

endpackage

@@ sv/gsg_div_step.sv @@
// ----------------------------------------------------------------------------
// gsg_div_step
// Compare-subtract unit: one restoring division step, shared by the
// modulo pass and the level division.
// ----------------------------------------------------------------------------
module gsg_div_step
  import gsg_pkg::*;
(
  input  logic [TrialW-1:0] trial,
  input  logic [FullW-1:0]  divisor,
  output logic              ge,
  output logic [TrialW-1:0] diff
);

  logic [TrialW:0] sub;

  // Subtract with one extra bit so the borrow tells the compare result
  assign sub  = {1'b0, trial} - {2'b00, divisor};
  assign ge   = ~sub[TrialW];
  assign diff = sub[TrialW-1:0];

endmodule

@@ sv/gsg_engine.sv @@
// ----------------------------------------------------------------------------
// gsg_engine
// Sequencer holding the phase offset. Runs multiply, add, a bit-serial
// modulo pass and a bit-serial level division on one shared step unit.
// ----------------------------------------------------------------------------
module gsg_engine
  import gsg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  gsg_cfg_t               cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [DtW-1:0]         delta_time,
  input  logic signed [PosW-1:0] position,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [LevelW-1:0]      res_level
);

  localparam int ProdW = DtW + 1 + SpeedW;
  localparam int StepW = SpeedW + 1;
  localparam int SumW  = StepW + 1;
  localparam int CntW  = $clog2(SumW);
  localparam logic [CntW-1:0] ModLast  = CntW'(SumW - 1);
  localparam logic [CntW-1:0] FracLast = CntW'(LevelW - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_STEP, S_ADD, S_MOD, S_CHK, S_FRAC, S_FIN
  } state_t;

  state_t                    state;
  logic                      op_r;
  logic [DtW-1:0]            dt_r;
  logic signed [PosW-1:0]    pos_r;
  logic signed [PhaseW-1:0]  phase;
  logic signed [ProdW-1:0]   prod;
  logic signed [StepW-1:0]   step;
  logic [SumW-1:0]           mag;
  logic                      neg;
  logic [FullW-1:0]          rem;
  logic [CntW-1:0]           cnt;
  logic [LevelW-1:0]         quo;

  logic [FullW-1:0]          full;
  logic [ProdW-1:0]          abs_prod;
  logic [SpeedW-1:0]         shifted;
  logic signed [SumW-1:0]    addend;
  logic signed [SumW-1:0]    sum;
  logic [TrialW-1:0]         trial;
  logic [FullW-1:0]          divisor;
  logic                      ge;
  logic [TrialW-1:0]         diff;
  logic [TrialW-1:0]         kept;

  assign full = {1'b0, cfg.saw_width} + {1'b0, cfg.gap_width};

  // Truncate the product toward zero
  assign abs_prod = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
  assign shifted  = abs_prod[ProdW-2 -: SpeedW];

  // Phase plus step or position
  assign addend = op_r ? SumW'(pos_r) : SumW'(step);
  assign sum    = SumW'(phase) + addend;

  // Feed the shared step unit
  always_comb begin
    if (state == S_FRAC) begin
      trial   = {rem, 1'b0};
      divisor = {1'b0, cfg.saw_width};
    end else begin
      trial   = {rem, mag[SumW-1]};
      divisor = full;
    end
  end

  gsg_div_step u_step (
    .trial   (trial),
    .divisor (divisor),
    .ge      (ge),
    .diff    (diff)
  );

  assign kept = ge ? diff : trial;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign res_level = quo;

  // Sequence one word through the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op;
            dt_r  <= delta_time;
            pos_r <= position;
            state <= (op == OpEval) ? S_ADD : S_MUL;
          end
        end
        S_MUL: begin
          prod  <= $signed({1'b0, dt_r}) * cfg.speed;
          state <= S_STEP;
        end
        S_STEP: begin
          step  <= prod[ProdW-1] ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
          state <= S_ADD;
        end
        S_ADD: begin
          cnt <= '0;
          rem <= '0;
          if (full == '0) begin
            // Zero full width: remainder is taken as zero
            neg   <= 1'b0;
            state <= S_CHK;
          end else begin
            neg   <= sum[SumW-1];
            mag   <= sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
            state <= S_MOD;
          end
        end
        S_MOD: begin
          rem <= kept[FullW-1:0];
          mag <= {mag[SumW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == ModLast) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          quo <= '0;
          cnt <= '0;
          if (op_r == OpTick) begin
            phase <= neg ? PhaseW'(-$signed({1'b0, rem})) : PhaseW'({1'b0, rem});
            state <= S_IDLE;
          end else if (!neg && rem != '0 && rem < {1'b0, cfg.saw_width}) begin
            rem   <= {1'b0, cfg.saw_width} - rem;
            state <= S_FRAC;
          end else begin
            state <= S_FIN;
          end
        end
        S_FRAC: begin
          rem <= kept[FullW-1:0];
          quo <= {quo[LevelW-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == FracLast) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/gapped_sawtooth_generator.sv @@
// ----------------------------------------------------------------------------
// gapped_sawtooth_generator
// Falling sawtooth with a zero gap, for LED strip animation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: op, delta_time and
//   position. A tick word (op 0) advances the phase by delta_time * speed,
//   shifted right by 16 with truncation toward zero, and folds it modulo
//   saw_width + gap_width; it gives no output word. An evaluate word (op 1)
//   returns one level word on the output channel (out_valid/out_ready).
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes speed (0), saw_width (1) and gap_width (2); it is always ready
//   and should be used only while the block is idle.
//   Sequence: a tick runs the states MUL, STEP, ADD, MOD and CHK before
//   in_ready returns; an evaluate runs ADD, MOD and CHK, then FRAC for a ramp
//   level, and waits in FIN. The single compare-subtract unit does 26 modulo
//   steps plus 16 level division steps, one bit per cycle.
//   Reset (rst, synchronous) clears the phase and loads the default
//   registers. When the receiver stalls, the level waits in the output
//   register while the next word is still taken and processed; a second
//   level waits in the engine until the register frees.
// ----------------------------------------------------------------------------
module gapped_sawtooth_generator
  import gsg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [DtW-1:0]         delta_time,
  input  logic signed [PosW-1:0] position,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LevelW-1:0]      level,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IdxW-1:0]        cfg_index,
  input  logic [DataW-1:0]       cfg_data
);

  gsg_cfg_t          cfg;
  logic              res_valid;
  logic              res_ready;
  logic [LevelW-1:0] res_level;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed     <= SpeedReset;
      cfg.saw_width <= SawWidthReset;
      cfg.gap_width <= GapWidthReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegSpeed:    cfg.speed     <= $signed(cfg_data);
        RegSawWidth: cfg.saw_width <= cfg_data[SawW-1:0];
        RegGapWidth: cfg.gap_width <= cfg_data[GapW-1:0];
        default: begin
        end
      endcase
    end
  end

  gsg_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .delta_time (delta_time),
    .position   (position),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_level  (res_level)
  );

  // Output register: take a new word when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      level <= res_level;
    end
  end

endmodule
